@@ design/wgm_pkg.sv @@
// wgm_pkg: shared constants, types and helpers of the wildcard glob matcher
// no dependencies; compiled first
`default_nettype none

package wgm_pkg;

    // pattern storage layout
    localparam int WORD_COUNT = 6;
    localparam int BYTE_W     = 8;
    localparam int CFG_W      = 64;
    localparam int LEN_W      = 6;
    localparam int CFG_IDX_W  = 3;

    // pattern metacharacters
    localparam logic [BYTE_W-1:0] CH_ANY  = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;

    // letter folding bounds
    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CFG_W-1:0]  t_cfg_word;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEN    = 3'd0,
        CFG_WORD_0 = 3'd1,
        CFG_WORD_1 = 3'd2,
        CFG_WORD_2 = 3'd3,
        CFG_WORD_3 = 3'd4,
        CFG_WORD_4 = 3'd5,
        CFG_WORD_5 = 3'd6
    } t_cfg_idx;

    // fold A-Z to a-z
    function automatic t_byte fold_case(input t_byte c);
        t_byte r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c + CASE_DELTA;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/wgm_in_if.sv @@
// wgm_in_if: name byte channel, valid/ready handshake
// depends on wgm_pkg
`default_nettype none

interface wgm_in_if;
    import wgm_pkg::*;

    logic  valid;
    logic  ready;
    t_byte name_char;
    logic  no_char;
    logic  last;

    modport source (output valid, output name_char, output no_char, output last,
                    input ready);
    modport sink   (input valid, input name_char, input no_char, input last,
                    output ready);
endinterface

`default_nettype wire

@@ design/wgm_out_if.sv @@
// wgm_out_if: verdict channel, valid/ready handshake
// no dependencies
`default_nettype none

interface wgm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic end_of_name;

    modport source (output valid, output matched, output end_of_name, input ready);
    modport sink   (input valid, input matched, input end_of_name, output ready);
endinterface

`default_nettype wire

@@ design/wgm_star_close.sv @@
// wgm_star_close: closes a live-position vector over runs of '*'
// parallel prefix network, log2(N) levels; no package dependency
`default_nettype none

module wgm_star_close #(
    parameter int N = 49
) (
    input  wire logic [N-1:0] i_live,
    input  wire logic [N-1:0] i_star,
    output logic      [N-1:0] o_live
);

    localparam int Levels = (N > 1) ? $clog2(N) : 1;

    // g: reachable, p: a live bit below passes through
    logic [N-1:0] g  [Levels+1];
    logic [N-1:0] pr [Levels];

    // position i is passed from i-1 when i-1 holds a star
    assign g[0]  = i_live;
    assign pr[0] = {i_star[N-2:0], 1'b0};

    for (genvar k = 0; k < Levels; k++) begin : g_level
        localparam int D = 1 << k;
        for (genvar i = 0; i < N; i++) begin : g_bit
            if (i >= D) begin : g_comb
                assign g[k+1][i] = g[k][i] | (pr[k][i] & g[k][i-D]);
                if (k + 1 < Levels) begin : g_prop
                    assign pr[k+1][i] = pr[k][i] & pr[k][i-D];
                end
            end else begin : g_pass
                assign g[k+1][i] = g[k][i];
                if (k + 1 < Levels) begin : g_prop
                    assign pr[k+1][i] = pr[k][i];
                end
            end
        end
    end

    assign o_live = g[Levels];

endmodule

`default_nettype wire

@@ design/wildcard_glob_matcher_unit.sv @@
// wildcard_glob_matcher_unit: top level of the case-insensitive glob matcher
// depends on wgm_pkg, wgm_in_if, wgm_out_if, wgm_star_close
//
// Takes one name byte per cycle unless the sink stalls and returns one verdict
// per beat from an output register. The live pattern positions are held in a
// PATTERN_MAX+1 bit vector whose next value comes from a star closure over the
// stored vector, a parallel compare of the byte against every pattern position,
// and a second star closure; both closures are log2 prefix networks. Input
// ready is high while the output register is empty or being drained, so a
// stalled sink stops intake only after one verdict is waiting. A beat with
// no_char set advances nothing and reports the verdict for the name so far; a
// beat with last set returns the matcher to its start position afterwards.
// Letters fold to lower case, '?' matches any byte, '*' any run of bytes. The
// user writes the pattern via the configuration port while idle; not enforced.
`default_nettype none

module wildcard_glob_matcher_unit #(
    parameter int PATTERN_MAX = 48
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [wgm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [wgm_pkg::CFG_W-1:0]   i_cfg_wdata,
    wgm_in_if.sink                           i_in,
    wgm_out_if.source                        o_out
);
    import wgm_pkg::*;

    localparam int NPos   = PATTERN_MAX + 1;
    localparam int PosW   = $clog2(NPos);
    localparam int NBytes = WORD_COUNT * 8;
    localparam logic [LEN_W-1:0] LenMax = LEN_W'(PATTERN_MAX);
    localparam logic [NPos-1:0]  LiveReset = NPos'(1);

    // configuration registers
    logic [LEN_W-1:0] r_len;
    t_cfg_word        r_pat [WORD_COUNT];

    // matcher state and output register
    logic [NPos-1:0] r_live;
    logic [NPos-1:0] n_live;
    logic            r_out_valid;
    logic            r_matched;
    logic            r_eon;
    logic            n_matched;

    logic            in_accept;
    logic [LEN_W-1:0] cur_len;
    t_byte           pat_byte [PATTERN_MAX];
    logic [NPos-1:0] len_mask;
    logic [NPos-1:0] star;
    logic [NPos-1:0] hit;
    logic [NPos-1:0] v_masked;
    logic [NPos-1:0] v_closed;
    logic [NPos-1:0] v_adv;
    logic [NPos-1:0] v_adv_closed;
    logic [NPos-1:0] v_next;
    t_byte           in_folded;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            for (int w = 0; w < WORD_COUNT; w++) begin
                r_pat[w] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx) inside
                CFG_LEN: begin
                    r_len <= i_cfg_wdata[LEN_W-1:0];
                end
                [CFG_WORD_0:CFG_WORD_5]: begin
                    r_pat[CFG_IDX_W'(i_cfg_idx - CFG_IDX_W'(CFG_WORD_0))] <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // effective length, clamped to PATTERN_MAX
    assign cur_len = (r_len > LenMax) ? LenMax : r_len;

    // pattern byte per position; positions past the words read as zero
    for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_pat
        if (p < NBytes) begin : g_word
            assign pat_byte[p] = r_pat[p / 8][(p % 8) * 8 +: 8];
        end else begin : g_zero
            assign pat_byte[p] = '0;
        end
    end

    assign in_folded = fold_case(i_in.name_char);

    // per-position decode: in range, star, byte hit
    always_comb begin
        len_mask = '0;
        star     = '0;
        hit      = '0;
        for (int p = 0; p < NPos; p++) begin
            len_mask[p] = (LEN_W'(p) <= cur_len);
        end
        for (int p = 0; p < PATTERN_MAX; p++) begin
            if (LEN_W'(p) < cur_len) begin
                star[p] = (pat_byte[p] == CH_STAR);
                hit[p]  = (pat_byte[p] != CH_STAR) &&
                          ((pat_byte[p] == CH_ANY) || (fold_case(pat_byte[p]) == in_folded));
            end
        end
    end

    assign v_masked = r_live & len_mask;

    wgm_star_close #(.N(NPos)) u_close_pre (
        .i_live (v_masked),
        .i_star (star),
        .o_live (v_closed)
    );

    // advance: a star holds its position, a hit moves one up
    assign v_adv = (v_closed & star) | {v_closed[NPos-2:0] & hit[NPos-2:0], 1'b0};

    wgm_star_close #(.N(NPos)) u_close_post (
        .i_live (v_adv),
        .i_star (star),
        .o_live (v_adv_closed)
    );

    assign v_next    = i_in.no_char ? v_closed : v_adv_closed;
    assign n_matched = v_next[cur_len[PosW-1:0]];
    assign n_live    = i_in.last ? LiveReset : v_next;

    // handshake
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    // live positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= LiveReset;
        end else if (in_accept) begin
            r_live <= n_live;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_matched <= n_matched;
            r_eon     <= i_in.last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.matched     = r_matched;
    assign o_out.end_of_name = r_eon;

endmodule

`default_nettype wire

@@ verif/wildcard_glob_matcher_unit_test.sv @@
// wildcard_glob_matcher_unit_test: self-checking bench for the glob matcher; name beats are
// scored by a bit-vector glob predictor and every verdict beat is compared in order
// depends on wgm_pkg, wgm_in_if, wgm_out_if and wildcard_glob_matcher_unit

module wildcard_glob_matcher_unit_test;
    import wgm_pkg::*;

    localparam int PMAX       = 48;
    localparam int GLOB_ITEMS = 1150;

    typedef struct packed {
        logic matched;
        logic end_of_name;
    } t_verdict;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    t_cfg_word            i_cfg_wdata;

    wgm_in_if  in_ch ();
    wgm_out_if out_ch ();

    wildcard_glob_matcher_unit #(
        .PATTERN_MAX(PMAX)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // predictor state: live pattern positions and a copy of the pattern registers
    logic [PMAX:0]    live_q;
    logic [LEN_W-1:0] pat_len_q;
    t_cfg_word        pat_words_q [WORD_COUNT];

    t_verdict verdicts_due [$];
    t_byte    pat_buf [PMAX];
    t_byte    name_buf [$];
    int       items_sent;
    int       mismatch_count;
    bit       calm;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3000000;
        $display("wildcard_glob_matcher_unit: mismatch");
        $finish;
    end

    // letters compare without case
    function automatic t_byte lower_letter(t_byte c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_DELTA) : c;
    endfunction

    function automatic t_byte pattern_byte(int p);
        return pat_words_q[p / 8][(p % 8) * BYTE_W +: BYTE_W];
    endfunction

    // oversized length clamps to the pattern capacity
    function automatic int active_len();
        return (int'(pat_len_q) > PMAX) ? PMAX : int'(pat_len_q);
    endfunction

    // a live star also makes the following position live
    function automatic logic [PMAX:0] follow_stars(logic [PMAX:0] v, int len);
        for (int p = 0; p < len; p++) begin
            if (v[p] && pattern_byte(p) == CH_STAR) begin
                v[p + 1] = 1'b1;
            end
        end
        return v;
    endfunction

    // advance the live positions by one beat and return its verdict
    function automatic t_verdict glob_step(t_byte ch, logic nc, logic lst);
        int            len;
        logic [PMAX:0] v;
        logic [PMAX:0] nv;
        t_byte         pb;
        t_verdict      vd;
        len = active_len();
        v   = '0;
        // positions above the current length are dropped
        for (int p = 0; p <= len; p++) begin
            v[p] = live_q[p];
        end
        v = follow_stars(v, len);
        if (!nc) begin
            nv = '0;
            for (int p = 0; p < len; p++) begin
                pb = pattern_byte(p);
                if (v[p] && pb == CH_STAR) begin
                    nv[p] = 1'b1;
                end else if (v[p] && (pb == CH_ANY || lower_letter(pb) == lower_letter(ch))) begin
                    nv[p + 1] = 1'b1;
                end
            end
            v = follow_stars(nv, len);
        end
        vd.matched     = v[len];
        vd.end_of_name = lst;
        live_q = lst ? {{PMAX{1'b0}}, 1'b1} : v;
        return vd;
    endfunction

    function automatic void log_mismatch(string what, logic want, logic got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t %s: expected %b got %b", $time, what, want, got);
        end
    endfunction

    // compare every verdict beat with the oldest one due
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (verdicts_due.size() == 0) begin
                log_mismatch("verdict beat with none due", 1'b0, out_ch.matched);
            end else begin
                want = verdicts_due.pop_front();
                if (out_ch.matched !== want.matched) begin
                    log_mismatch("matched", want.matched, out_ch.matched);
                end
                if (out_ch.end_of_name !== want.end_of_name) begin
                    log_mismatch("end_of_name", want.end_of_name, out_ch.end_of_name);
                end
            end
        end
    end

    // verdict sink stalls at random outside the calm stretch
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 7);
        end
    end

    // send one name beat, entered and left at a falling edge
    task automatic send_beat(input t_byte ch, input logic nc, input logic lst);
        if (!calm && $urandom_range(0, 99) < 4) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.name_char <= ch;
        in_ch.no_char   <= nc;
        in_ch.last      <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        verdicts_due.insert(verdicts_due.size(), glob_step(ch, nc, lst));
        items_sent++;
        @(negedge i_clk);
    endtask

    // stop sending and let every verdict come back
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // register write; the caller lowers the write enable after its last write
    task automatic cfg_write(input t_cfg_idx idx, input t_cfg_word data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        if (idx == CFG_LEN) begin
            pat_len_q = data[LEN_W-1:0];
        end else begin
            pat_words_q[idx - CFG_WORD_0] = data;
        end
    endtask

    task automatic set_length(input int len_val);
        cfg_write(CFG_LEN, t_cfg_word'(len_val));
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_cfg_word pack_word(int w);
        t_cfg_word pw;
        for (int b = 0; b < 8; b++) begin
            pw[b * BYTE_W +: BYTE_W] = pat_buf[w * 8 + b];
        end
        return pw;
    endfunction

    task automatic load_pattern(input int len_val);
        cfg_write(CFG_LEN, t_cfg_word'(len_val));
        for (int w = 0; w < WORD_COUNT; w++) begin
            cfg_write(t_cfg_idx'(CFG_WORD_0 + w), pack_word(w));
        end
        i_cfg_we <= 1'b0;
    endtask

    // pattern text, zero bytes after it
    function automatic void fill_text(string s);
        for (int i = 0; i < PMAX; i++) begin
            pat_buf[i] = (i < s.len()) ? t_byte'(s[i]) : '0;
        end
    endfunction

    task automatic send_text(input string s);
        if (s.len() == 0) begin
            send_beat(8'h00, 1'b1, 1'b1);
        end else begin
            for (int i = 0; i < s.len(); i++) begin
                send_beat(t_byte'(s[i]), 1'b0, i == s.len() - 1);
            end
        end
    endtask

    function automatic t_byte flip_case(t_byte c);
        t_byte lc;
        lc = lower_letter(c);
        if (lc >= "a" && lc <= "z" && $urandom_range(0, 1)) begin
            return c ^ CASE_DELTA;
        end
        return c;
    endfunction

    function automatic t_byte random_name_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return flip_case(t_byte'("a" + $urandom_range(0, 25)));
        end else if (roll < 65) begin
            return CH_STAR;
        end
        return t_byte'($urandom_range(0, 255));
    endfunction

    function automatic t_byte random_pattern_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 22) begin
            return CH_STAR;
        end else if (roll < 40) begin
            return CH_ANY;
        end else if (roll < 85) begin
            return flip_case(t_byte'("a" + $urandom_range(0, 25)));
        end
        return t_byte'($urandom_range(0, 255));
    endfunction

    // mostly short patterns, with empty, full and oversized lengths mixed in
    task automatic random_pattern();
        int roll;
        int len_val;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            len_val = 0;
        end else if (roll < 18) begin
            len_val = PMAX;
        end else if (roll < 26) begin
            len_val = $urandom_range(PMAX + 1, 63);
        end else begin
            len_val = $urandom_range(1, 10);
        end
        foreach (pat_buf[i]) begin
            pat_buf[i] = random_pattern_byte();
        end
        load_pattern(len_val);
    endtask

    // names that follow the pattern, some of them corrupted, plus plain noise
    function automatic void build_name();
        int    len;
        int    roll;
        int    pos;
        t_byte pb;
        name_buf.delete();
        len  = active_len();
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            for (int p = 0; p < len; p++) begin
                pb = pattern_byte(p);
                if (pb == CH_STAR) begin
                    repeat ($urandom_range(0, 3))
                        name_buf.insert(name_buf.size(), random_name_byte());
                end else if (pb == CH_ANY) begin
                    name_buf.insert(name_buf.size(), random_name_byte());
                end else begin
                    name_buf.insert(name_buf.size(), flip_case(pb));
                end
            end
            if (roll >= 55 && name_buf.size() > 0) begin
                pos = $urandom_range(0, name_buf.size() - 1);
                case ($urandom_range(0, 2))
                    0: begin
                        name_buf[pos] = random_name_byte();
                    end
                    1: begin
                        name_buf.delete(pos);
                    end
                    default: begin
                        name_buf.insert(pos, random_name_byte());
                    end
                endcase
            end
        end else begin
            repeat ($urandom_range(0, 8)) name_buf.insert(name_buf.size(), random_name_byte());
        end
    endfunction

    // pattern change in the middle of a name, with the sender held until drained
    task automatic rewrite_midname();
        int w;
        if ($urandom_range(0, 1)) begin
            set_length($urandom_range(0, 63));
        end else begin
            w = $urandom_range(0, WORD_COUNT - 1);
            for (int b = 0; b < 8; b++) begin
                pat_buf[w * 8 + b] = random_pattern_byte();
            end
            cfg_write(t_cfg_idx'(CFG_WORD_0 + w), pack_word(w));
            i_cfg_we <= 1'b0;
        end
    endtask

    task automatic send_name();
        bit trailer;
        trailer = (name_buf.size() == 0) || ($urandom_range(0, 9) == 0);
        foreach (name_buf[i]) begin
            if ($urandom_range(0, 99) < 2) begin
                wait_idle();
                rewrite_midname();
            end
            if ($urandom_range(0, 99) < 5) begin
                send_beat(t_byte'($urandom), 1'b1, 1'b0);
            end
            send_beat(name_buf[i], 1'b0, !trailer && i == name_buf.size() - 1);
        end
        // empty names and some others end on a beat without a byte
        if (trailer) begin
            send_beat(t_byte'($urandom), 1'b1, 1'b1);
        end
    endtask

    // reset pattern is empty: only the empty name matches
    task automatic test_empty_pattern();
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hFF, 1'b0, 1'b1);
    endtask

    // literal with folded case, any-byte on 0xff, trailing zero byte as a literal
    task automatic test_literals_and_any();
        wait_idle();
        fill_text("a?C");
        load_pattern(4);
        send_beat("A", 1'b0, 1'b0);
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat("c", 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    // star matches the empty run and a literal star byte in the name
    task automatic test_star_runs();
        wait_idle();
        fill_text("*");
        load_pattern(1);
        send_beat(8'h5A, 1'b1, 1'b1);
        send_text("Q*");
    endtask

    // lengths above capacity are clamped
    task automatic test_length_clamp();
        wait_idle();
        foreach (pat_buf[i]) begin
            pat_buf[i] = CH_STAR;
        end
        pat_buf[PMAX - 1] = "k";
        load_pattern(63);
        send_text("K");
        send_beat(8'h00, 1'b1, 1'b1);
        wait_idle();
        set_length(PMAX + 1);
        send_text("zk");
    endtask

    // beats without a byte advance nothing
    task automatic test_no_char_items();
        wait_idle();
        fill_text("ab");
        load_pattern(2);
        send_beat("a", 1'b0, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat("B", 1'b0, 1'b0);
        send_beat(8'h00, 1'b1, 1'b1);
    endtask

    // length changes in a name keep live positions but drop those above the length
    task automatic test_midname_config();
        wait_idle();
        fill_text("abcd");
        load_pattern(4);
        send_beat("a", 1'b0, 1'b0);
        send_beat("b", 1'b0, 1'b0);
        wait_idle();
        set_length(2);
        send_beat(8'h00, 1'b1, 1'b1);
        wait_idle();
        set_length(4);
        send_text("ab");
        send_beat("c", 1'b0, 1'b0);
        wait_idle();
        set_length(2);
        send_beat(8'h00, 1'b1, 1'b0);
        wait_idle();
        set_length(4);
        send_beat("d", 1'b0, 1'b1);
    endtask

    // random patterns with names built from them, calm stretch in the middle
    task automatic test_random_names();
        int first;
        int names_left;
        first      = items_sent;
        names_left = 0;
        while (items_sent - first < GLOB_ITEMS) begin
            calm = (items_sent - first >= 450) && (items_sent - first < 650);
            if (names_left == 0) begin
                wait_idle();
                random_pattern();
                names_left = $urandom_range(1, 6);
            end
            build_name();
            send_name();
            names_left--;
        end
        calm = 1'b0;
    endtask

    // reset, tests in turn, final verdict
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_LEN;
        i_cfg_wdata     = '0;
        in_ch.valid     = 1'b0;
        in_ch.name_char = '0;
        in_ch.no_char   = 1'b0;
        in_ch.last      = 1'b0;
        live_q          = {{PMAX{1'b0}}, 1'b1};
        pat_len_q       = '0;
        foreach (pat_words_q[i]) begin
            pat_words_q[i] = '0;
        end
        items_sent     = 0;
        mismatch_count = 0;
        calm           = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pattern();
        test_literals_and_any();
        test_star_runs();
        test_length_clamp();
        test_no_char_items();
        test_midname_config();
        test_random_names();

        wait_idle();
        repeat (4) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("wildcard_glob_matcher_unit: match");
        end else begin
            $display("wildcard_glob_matcher_unit: mismatch");
        end
        $finish;
    end

endmodule

@@ wildcard_glob_matcher_unit.f @@
design/wgm_pkg.sv
design/wgm_in_if.sv
design/wgm_out_if.sv
design/wgm_star_close.sv
design/wildcard_glob_matcher_unit.sv
verif/wildcard_glob_matcher_unit_test.sv
